@@ rtl/jqhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqhs_pkg: shared types for the job queue with history stack
// Request and status codes, and the request and result bundles that pass
// between the top level and the core.
// ----------------------------------------------------------------------------
package jqhs_pkg;

    localparam int JOB_W     = 16;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 24;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_PROCESS = 2'd1,
        REQ_POP     = 2'd2
    } req_e_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_QFULL  = 3'd1,
        ST_QEMPTY = 3'd2,
        ST_HFULL  = 3'd3,
        ST_HEMPTY = 3'd4
    } status_e_t;

    // one request beat as seen by the core
    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [JOB_W-1:0] job_id;
    } jqhs_req_t;

    // per-request result, counts travel separately
    typedef struct packed {
        status_e_t        status;
        logic [JOB_W-1:0] job_out;
        logic [JOB_W-1:0] queue_front;
        logic             queue_front_valid;
        logic [JOB_W-1:0] history_top;
        logic             history_top_valid;
    } jqhs_res_t;

endpackage

`default_nettype wire

@@ rtl/jqhs_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqhs_core: waiting ring and history stack
// Holds both stores, their pointers and cached head/top values, and works
// out one request per cycle. Results are combinational from current state.
// ----------------------------------------------------------------------------
module jqhs_core
    import jqhs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16,
    localparam int QPTR_W = $clog2(QUEUE_DEPTH),
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int HPTR_W = $clog2(HISTORY_DEPTH),
    localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              req_fire,
    input  wire jqhs_req_t         req,
    output jqhs_res_t              res,
    output logic [QCNT_W-1:0]      q_count,
    output logic [HCNT_W-1:0]      h_count
);

    // storage
    logic [JOB_W-1:0] q_mem [QUEUE_DEPTH];
    logic [JOB_W-1:0] h_mem [HISTORY_DEPTH];

    // pointers and counts
    logic [QPTR_W-1:0] q_head_reg, q_head_next;
    logic [QPTR_W-1:0] q_tail_reg, q_tail_next;
    logic [QCNT_W-1:0] q_fill_reg, q_fill_next;
    logic [HCNT_W-1:0] h_fill_reg, h_fill_next;

    // cached entries: queue head, entry behind it, history top, entry below it
    logic [JOB_W-1:0] q_front_reg, q_front_next;
    logic [JOB_W-1:0] q_second_reg;
    logic [JOB_W-1:0] h_top_reg, h_top_next;
    logic [JOB_W-1:0] h_below_reg;

    logic              q_we;
    logic              h_we;
    logic [QPTR_W-1:0] q_rd_addr;
    logic [HPTR_W-1:0] h_rd_addr;
    logic [HCNT_W-1:0] h_rd_cnt;
    logic              q_full, q_empty, h_full, h_empty;
    status_e_t         status;
    logic [JOB_W-1:0]  job_out;

    function automatic logic [QPTR_W-1:0] q_inc(input logic [QPTR_W-1:0] p);
        q_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_full  = (q_fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (q_fill_reg == '0);
    assign h_full  = (h_fill_reg == HCNT_W'(HISTORY_DEPTH));
    assign h_empty = (h_fill_reg == '0);

    // request decode and next state
    always_comb begin
        q_head_next  = q_head_reg;
        q_tail_next  = q_tail_reg;
        q_fill_next  = q_fill_reg;
        h_fill_next  = h_fill_reg;
        q_front_next = q_front_reg;
        h_top_next   = h_top_reg;
        q_we         = 1'b0;
        h_we         = 1'b0;
        status       = ST_OK;
        job_out      = '0;
        if (req_fire) begin
            case (req.req_type)
                REQ_ENQUEUE: begin
                    if (q_full) begin
                        status = ST_QFULL;
                    end else begin
                        q_we        = 1'b1;
                        q_tail_next = q_inc(q_tail_reg);
                        q_fill_next = q_fill_reg + 1'b1;
                        if (q_empty) begin
                            q_front_next = req.job_id;
                        end
                    end
                end
                REQ_PROCESS: begin
                    if (q_empty) begin
                        status = ST_QEMPTY;
                    end else begin
                        q_head_next  = q_inc(q_head_reg);
                        q_fill_next  = q_fill_reg - 1'b1;
                        q_front_next = q_second_reg;
                        if (h_full) begin
                            status = ST_HFULL;
                        end else begin
                            h_we        = 1'b1;
                            h_fill_next = h_fill_reg + 1'b1;
                            h_top_next  = q_front_reg;
                            job_out     = q_front_reg;
                        end
                    end
                end
                REQ_POP: begin
                    if (h_empty) begin
                        status = ST_HEMPTY;
                    end else begin
                        h_fill_next = h_fill_reg - 1'b1;
                        job_out     = h_top_reg;
                        h_top_next  = h_below_reg;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
    end

    // prefetch addresses follow the updated pointers
    assign q_rd_addr = q_inc(q_head_next);
    assign h_rd_cnt  = h_fill_next - HCNT_W'(2);
    assign h_rd_addr = h_rd_cnt[HPTR_W-1:0];

    // result as it stands after the step
    always_comb begin
        res.status            = status;
        res.job_out           = job_out;
        res.queue_front_valid = (q_fill_next != '0);
        res.queue_front       = res.queue_front_valid ? q_front_next : '0;
        res.history_top_valid = (h_fill_next != '0);
        res.history_top       = res.history_top_valid ? h_top_next : '0;
        q_count               = q_fill_next;
        h_count               = h_fill_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_fill_reg <= '0;
            h_fill_reg <= '0;
        end else begin
            q_head_reg <= q_head_next;
            q_tail_reg <= q_tail_next;
            q_fill_reg <= q_fill_next;
            h_fill_reg <= h_fill_next;
        end
    end

    // cached payload
    always_ff @(posedge aclk) begin
        q_front_reg <= q_front_next;
        h_top_reg   <= h_top_next;
    end

    // waiting ring: write at tail, registered read behind the head with write bypass
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_tail_reg] <= req.job_id;
        end
        if (q_we && (q_tail_reg == q_rd_addr)) begin
            q_second_reg <= req.job_id;
        end else begin
            q_second_reg <= q_mem[q_rd_addr];
        end
    end

    // history stack: push at fill, registered read of the entry below the top
    always_ff @(posedge aclk) begin
        if (h_we) begin
            h_mem[h_fill_reg[HPTR_W-1:0]] <= q_front_reg;
        end
        h_below_reg <= h_mem[h_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/job_queue_with_history_stack_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// job_queue_with_history_stack_top: job spooler with FIFO and LIFO history
// Requests enqueue a job, move the queue head to the history stack (drop it if
// full), or pop the newest history entry; each request returns one status beat.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)
//  ---------+-----+----------------------------------------------------------
//  s_       | in  | req_type[1:0], job_id[17:2], zero pad
//  m_       | out | status, job_out, queue_front, queue_front_valid,
//           |     | history_top, history_top_valid, queue_count, history_count
//
//  one request per cycle unless stalled; its result beat is in the next cycle
//  store state updates at the accepting edge, using one prefetch read per store
//  reset clears pointers and fill counts; stores are not cleared
//  s_tready drops only while a result beat sits unaccepted with m_tready low
// ----------------------------------------------------------------------------
module job_queue_with_history_stack_top
    import jqhs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16,
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int HCNT_W    = $clog2(HISTORY_DEPTH + 1),
    localparam int OUT_RAW_W = STATUS_W + 4 * JOB_W - JOB_W + 2 + QCNT_W + HCNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // req_type, job_id
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // status, job_out, queue_front,
                                                 // queue_front_valid, history_top,
                                                 // history_top_valid, queue_count,
                                                 // history_count
);

    logic              s_fire;
    jqhs_req_t         req;
    jqhs_res_t         res;
    logic [QCNT_W-1:0] q_count;
    logic [HCNT_W-1:0] h_count;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    // input beat unpack
    assign s_tready     = !m_valid_reg || m_tready;
    assign s_fire       = s_tvalid && s_tready;
    assign req.req_type = s_tdata[REQ_W-1:0];
    assign req.job_id   = s_tdata[REQ_W +: JOB_W];

    jqhs_core #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_fire (s_fire),
        .req      (req),
        .res      (res),
        .q_count  (q_count),
        .h_count  (h_count)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            m_data_next  = OUT_W'({h_count, q_count,
                                   res.history_top_valid, res.history_top,
                                   res.queue_front_valid, res.queue_front,
                                   res.job_out, res.status});
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/jqhs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jqhs_checker: port-level checks for the job spooler
// Watches the result channel and checks stall behavior and field consistency.
// ----------------------------------------------------------------------------
module jqhs_checker
    import jqhs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16,
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int HCNT_W    = $clog2(HISTORY_DEPTH + 1),
    localparam int OUT_RAW_W = STATUS_W + 3 * JOB_W + 2 + QCNT_W + HCNT_W,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8,
    localparam int JOB_LO    = STATUS_W,
    localparam int FV_BIT    = STATUS_W + 2 * JOB_W,
    localparam int TV_BIT    = STATUS_W + 3 * JOB_W + 1,
    localparam int QC_LO     = TV_BIT + 1,
    localparam int HC_LO     = QC_LO + QCNT_W
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    job_out;
    logic [QCNT_W-1:0]   q_count;
    logic [HCNT_W-1:0]   h_count;

    assign status  = m_tdata[STATUS_W-1:0];
    assign job_out = m_tdata[JOB_LO +: JOB_W];
    assign q_count = m_tdata[QC_LO +: QCNT_W];
    assign h_count = m_tdata[HC_LO +: HCNT_W];

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // queue front valid tracks queue count
    a_front_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[FV_BIT] == (q_count != '0)))
        else $error("queue front valid disagrees with queue count");

    // history top valid tracks history count
    a_top_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[TV_BIT] == (h_count != '0)))
        else $error("history top valid disagrees with history count");

    // dropped job only with a full history and no job reported
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == ST_HFULL) |->
            (h_count == HCNT_W'(HISTORY_DEPTH)) && (job_out == '0))
        else $error("drop reported without full history");

    // fill counts stay within the store depths
    a_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (q_count <= QCNT_W'(QUEUE_DEPTH)) &&
                     (h_count <= HCNT_W'(HISTORY_DEPTH)))
        else $error("fill count beyond store depth");

endmodule

bind job_queue_with_history_stack_top jqhs_checker #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_jqhs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
